/* design/pme_pkg.sv */
// Shared constants, types and helpers for the polynomial map evaluator.
package pme_pkg;
	localparam int MAX_POINT_DIMS = 4;
	localparam int MAX_VALUE_DIMS = 4;
	localparam int MAX_TERMS = 35;
	localparam int FRAC_BITS = 16;
	localparam int STORE_DEPTH = MAX_VALUE_DIMS * MAX_TERMS;
	localparam int STORE_AW = $clog2(STORE_DEPTH);
	localparam int TERM_W = 6;
	localparam int ROW_W = 2;
	localparam int DEG_W = 6;
	localparam int ACC_W = 48;

	localparam logic [1:0] CFG_POINT_DIMS = 2'd0;
	localparam logic [1:0] CFG_NUM_TERMS = 2'd1;
	localparam logic [1:0] CFG_VALUE_DIMS = 2'd2;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	// multiplier operand select
	localparam logic MSEL_TERM = 1'b0;
	localparam logic MSEL_COEF = 1'b1;

	typedef struct packed {
		logic clr_acc;       // start of evaluation
		logic term_init;     // term := 1.0
		logic mul_go;        // launch a multiply
		logic mul_sel;       // MSEL_*
		logic [1:0] coord;   // coordinate for term multiply
		logic acc_en;        // registered product lands in accumulator
		logic [ROW_W-1:0] acc_row;
		logic term_en;       // registered product lands in term
		logic cap_point;
	} pme_cmd_t;

	// round half up then shift
	function automatic logic signed [63:0] fx_round(input logic signed [63:0] p);
		logic signed [63:0] s;
		s = p + (64'sd1 <<< (FRAC_BITS - 1));
		return s >>> FRAC_BITS;
	endfunction
endpackage

/* design/pme_ram.sv */
// Generic single-port-write, registered-read RAM.
module pme_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 140
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

/* design/pme_datapath.sv */
// Datapath: coordinate registers, shared multiplier, term and row accumulators.
module pme_datapath (
	input  logic clk,
	input  logic arst_n,
	input  pme_pkg::pme_cmd_t cmd,
	input  logic signed [31:0] x0,
	input  logic signed [31:0] x1,
	input  logic signed [31:0] x2,
	input  logic signed [31:0] x3,
	input  logic signed [31:0] coef,
	input  logic [pme_pkg::ROW_W-1:0] rd_row,
	output logic signed [31:0] rd_value,
	output logic rd_sat
);
	logic signed [31:0] x_q [4];
	logic signed [31:0] term_q;
	logic signed [pme_pkg::ACC_W-1:0] acc_q [pme_pkg::MAX_VALUE_DIMS];
	logic signed [63:0] prod_q;
	logic sat_q;
	logic signed [31:0] op_a, op_b;
	logic signed [63:0] rnd;
	logic signed [pme_pkg::ACC_W:0] sum;
	logic signed [pme_pkg::ACC_W-1:0] rd_acc;

	always_comb begin
		op_a = term_q;
		op_b = (cmd.mul_sel == pme_pkg::MSEL_COEF) ? coef : x_q[cmd.coord];
	end

	assign rnd = pme_pkg::fx_round(prod_q);
	assign sum = {acc_q[cmd.acc_row][pme_pkg::ACC_W-1], acc_q[cmd.acc_row]}
		+ rnd[pme_pkg::ACC_W:0];

	always_ff @(posedge clk) begin
		if (cmd.cap_point) begin
			x_q[0] <= x0; x_q[1] <= x1; x_q[2] <= x2; x_q[3] <= x3;
		end
		if (cmd.mul_go) prod_q <= 64'(op_a) * 64'(op_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_q <= '0;
			sat_q <= 1'b0;
			for (int r = 0; r < pme_pkg::MAX_VALUE_DIMS; r++) acc_q[r] <= '0;
		end else begin
			if (cmd.clr_acc) begin
				sat_q <= 1'b0;
				for (int r = 0; r < pme_pkg::MAX_VALUE_DIMS; r++) acc_q[r] <= '0;
			end
			if (cmd.term_init) term_q <= 32'sd1 <<< pme_pkg::FRAC_BITS;
			if (cmd.term_en) begin
				if (rnd > 64'sh7FFFFFFF) begin
					term_q <= 32'sh7FFFFFFF; sat_q <= 1'b1;
				end else if (rnd < -64'sh80000000) begin
					term_q <= 32'sh80000000; sat_q <= 1'b1;
				end else term_q <= rnd[31:0];
			end
			if (cmd.acc_en) begin
				// rnd fits in 48 bits: |coef*term| <= 2^62, shifted by 16
				if (sum > $signed({2'b00, {(pme_pkg::ACC_W-1){1'b1}}}))
					acc_q[cmd.acc_row] <= {1'b0, {(pme_pkg::ACC_W-1){1'b1}}};
				else if (sum < $signed({2'b11, {(pme_pkg::ACC_W-1){1'b0}}}))
					acc_q[cmd.acc_row] <= {1'b1, {(pme_pkg::ACC_W-1){1'b0}}};
				else acc_q[cmd.acc_row] <= sum[pme_pkg::ACC_W-1:0];
			end
		end
	end

	assign rd_acc = acc_q[rd_row];
	always_comb begin
		if (rd_acc > 48'sh00007FFFFFFF) begin
			rd_value = 32'sh7FFFFFFF; rd_sat = 1'b1;
		end else if (rd_acc < -48'sh000080000000) begin
			rd_value = 32'sh80000000; rd_sat = 1'b1;
		end else begin
			rd_value = rd_acc[31:0]; rd_sat = sat_q;
		end
	end
endmodule

/* design/pme_ctrl.sv */
// Controller: monomial enumeration, multiply sequencing and output beats.
module pme_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic op,
	input  logic [2:0] point_dims,
	input  logic [5:0] num_terms,
	input  logic [2:0] value_dims,
	input  logic out_fire,
	output logic in_ready,
	output logic out_valid,
	output logic [pme_pkg::ROW_W-1:0] out_row,
	output logic out_last,
	output logic [pme_pkg::STORE_AW-1:0] raddr,
	output pme_pkg::pme_cmd_t cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_TMUL = 3'd1; // term multiply issue
	localparam logic [2:0] S_TWB = 3'd2;  // term writeback
	localparam logic [2:0] S_CRD = 3'd3;  // coefficient read
	localparam logic [2:0] S_CMUL = 3'd4; // coef multiply issue
	localparam logic [2:0] S_CWB = 3'd5;  // accumulate
	localparam logic [2:0] S_OUT = 3'd6;

	logic [2:0] state_q;
	// exponent of each coordinate; the sorted index list is implied by these counts
	logic [pme_pkg::DEG_W-1:0] cnt_q [4];
	logic [pme_pkg::DEG_W-1:0] len_q, k_q;
	logic [pme_pkg::TERM_W-1:0] t_q;
	logic [pme_pkg::ROW_W-1:0] r_q;
	logic [1:0] dtop, nv_m1;
	logic [pme_pkg::TERM_W-1:0] nt;
	logic [2:0] dims_c;
	logic [2:0] nv_c;
	logic [1:0] vsel;
	logic [pme_pkg::DEG_W-1:0] cum1, cum2, cum3;
	logic [1:0] coord;
	logic last_term, last_row;
	logic [pme_pkg::DEG_W-1:0] cnt_n [4];
	logic [pme_pkg::DEG_W-1:0] len_n;

	always_comb begin
		dims_c = (point_dims == 3'd0) ? 3'd1 : (point_dims > 3'd4) ? 3'd4 : point_dims;
		dtop = 2'(dims_c - 3'd1);
		nt = (num_terms == '0) ? 6'd1 : (num_terms > 6'(pme_pkg::MAX_TERMS))
			? 6'(pme_pkg::MAX_TERMS) : num_terms;
		nv_c = (value_dims == 3'd0) ? 3'd1 : (value_dims > 3'd4) ? 3'd4 : value_dims;
		nv_m1 = 2'(nv_c - 3'd1);
		last_term = (t_q == nt - 6'd1);
		last_row = (r_q == nv_m1);
	end

	// position k of the sorted list: coordinate whose cumulative count passes k
	always_comb begin
		cum1 = cnt_q[0];
		cum2 = cum1 + cnt_q[1];
		cum3 = cum2 + cnt_q[2];
		coord = (k_q < cum1) ? 2'd0 : (k_q < cum2) ? 2'd1 : (k_q < cum3) ? 2'd2 : 2'd3;
	end

	// next monomial: when every index sits at top the degree grows, otherwise the
	// highest index below top moves up one and absorbs the trailing top entries
	always_comb begin
		for (int i = 0; i < 4; i++) cnt_n[i] = cnt_q[i];
		len_n = len_q;
		vsel = '0;
		for (int i = 0; i < 3; i++)
			if (2'(i) < dtop && cnt_q[i] != '0) vsel = 2'(i);
		if (len_q == '0) begin
			cnt_n[0] = 6'd1; len_n = 6'd1;
		end else if (cnt_q[dtop] == len_q) begin
			len_n = len_q + 6'd1;
			for (int i = 0; i < 4; i++) cnt_n[i] = '0;
			cnt_n[0] = len_q + 6'd1;
		end else begin
			cnt_n[vsel] = cnt_q[vsel] - 6'd1;
			cnt_n[dtop] = '0;
			cnt_n[vsel + 2'd1] = cnt_q[dtop] + 6'd1;
		end
	end

	assign raddr = pme_pkg::STORE_AW'(r_q * pme_pkg::MAX_TERMS + t_q);

	always_comb begin
		cmd = '0;
		cmd.coord = coord;
		cmd.acc_row = r_q;
		cmd.cap_point = in_fire && op == pme_pkg::OP_EVAL;
		cmd.clr_acc = cmd.cap_point;
		cmd.term_init = cmd.cap_point;
		unique case (state_q)
			S_TMUL: begin cmd.mul_go = 1'b1; cmd.mul_sel = pme_pkg::MSEL_TERM; end
			S_TWB: cmd.term_en = 1'b1;
			S_CMUL: begin cmd.mul_go = 1'b1; cmd.mul_sel = pme_pkg::MSEL_COEF; end
			S_CWB: cmd.acc_en = 1'b1;
			default: ;
		endcase
		if (state_q == S_CWB && last_row && !last_term) cmd.term_init = 1'b1;
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_row = r_q;
	assign out_last = last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q <= '0; k_q <= '0; t_q <= '0; r_q <= '0;
			for (int i = 0; i < 4; i++) cnt_q[i] <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_fire && op == pme_pkg::OP_EVAL) begin
					len_q <= '0; k_q <= '0; t_q <= '0; r_q <= '0;
					for (int i = 0; i < 4; i++) cnt_q[i] <= '0;
					state_q <= S_CRD;
				end
				S_TMUL: state_q <= S_TWB;
				S_TWB: begin
					k_q <= k_q + 6'd1;
					state_q <= (k_q + 6'd1 == len_q) ? S_CRD : S_TMUL;
				end
				S_CRD: state_q <= S_CMUL;
				S_CMUL: state_q <= S_CWB;
				S_CWB: begin
					if (!last_row) begin
						r_q <= r_q + 2'd1; state_q <= S_CRD;
					end else if (!last_term) begin
						r_q <= '0; t_q <= t_q + 6'd1; k_q <= '0;
						for (int i = 0; i < 4; i++) cnt_q[i] <= cnt_n[i];
						len_q <= len_n;
						state_q <= S_TMUL;
					end else begin
						r_q <= '0; state_q <= S_OUT;
					end
				end
				S_OUT: if (out_fire) begin
					r_q <= r_q + 2'd1;
					if (last_row) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_fire |=> out_valid && $stable(out_row)) else $error("out hold");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("busy overlap");
	a_deg: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TMUL |-> k_q < len_q) else $error("degree index");
endmodule

/* design/polynomial_map_evaluator.sv */
// Top level of the polynomial map evaluator.
//  channel | dir | handshake            | payload
//  in      | in  | in_valid/in_ready    | op coef_row coef_term coef_value x0..x3
//  out     | out | out_valid/out_ready  | out_index out_value overflow last
//  cfg     | in  | cfg_valid/cfg_ready  | cfg_index cfg_data
// Every term and coefficient product of an evaluation goes through the single
// shared 32x32 multiplier and its result register.
// Reset clears the control state and sets the configuration to 4 point dims,
// 1 term and 1 value dim; the coefficient store is then cleared by a sweep of
// all 140 entries, during which in_ready stays low.
// Output stalls hold the block; no new beat is taken until the last row leaves.
module polynomial_map_evaluator (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic op,
	input  logic [1:0] coef_row,
	input  logic [5:0] coef_term,
	input  logic signed [31:0] coef_value,
	input  logic signed [31:0] x0,
	input  logic signed [31:0] x1,
	input  logic signed [31:0] x2,
	input  logic signed [31:0] x3,
	output logic out_valid,
	input  logic out_ready,
	output logic [1:0] out_index,
	output logic signed [31:0] out_value,
	output logic overflow,
	output logic last,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [5:0] cfg_data
);
	logic [2:0] point_dims_q, value_dims_q;
	logic [5:0] num_terms_q;
	logic [pme_pkg::STORE_AW-1:0] clr_q;
	logic clr_busy_q;
	logic ctrl_ready, in_fire, out_fire;
	logic we;
	logic [pme_pkg::STORE_AW-1:0] waddr, raddr;
	logic [31:0] wdata, rdata;
	pme_pkg::pme_cmd_t cmd;

	assign cfg_ready = 1'b1;
	assign in_ready = ctrl_ready && !clr_busy_q;
	assign in_fire = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_dims_q <= 3'd4; num_terms_q <= 6'd1; value_dims_q <= 3'd1;
			clr_q <= '0; clr_busy_q <= 1'b1;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					pme_pkg::CFG_POINT_DIMS: point_dims_q <= cfg_data[2:0];
					pme_pkg::CFG_NUM_TERMS: num_terms_q <= cfg_data;
					pme_pkg::CFG_VALUE_DIMS: value_dims_q <= cfg_data[2:0];
					default: ;
				endcase
			end
			if (clr_busy_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == pme_pkg::STORE_AW'(pme_pkg::STORE_DEPTH - 1)) clr_busy_q <= 1'b0;
			end
		end
	end

	always_comb begin
		if (clr_busy_q) begin
			we = 1'b1; waddr = clr_q; wdata = '0;
		end else begin
			we = in_fire && op == pme_pkg::OP_WRITE && coef_term < 6'(pme_pkg::MAX_TERMS);
			waddr = pme_pkg::STORE_AW'(coef_row * pme_pkg::MAX_TERMS + coef_term);
			wdata = coef_value;
		end
	end

	pme_ram #(.WIDTH(32), .DEPTH(pme_pkg::STORE_DEPTH)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata));

	pme_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .op(op),
		.point_dims(point_dims_q), .num_terms(num_terms_q), .value_dims(value_dims_q),
		.out_fire(out_fire), .in_ready(ctrl_ready), .out_valid(out_valid),
		.out_row(out_index), .out_last(last), .raddr(raddr), .cmd(cmd));

	pme_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .x0(x0), .x1(x1), .x2(x2), .x3(x3),
		.coef(rdata), .rd_row(out_index), .rd_value(out_value),
		.rd_sat(overflow));

	a_no_in_clr: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !in_fire) else $error("input during clear");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && last |=> !out_valid) else $error("beat after last");
	a_clr_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_busy_q) |-> $past(clr_q) == pme_pkg::STORE_AW'(pme_pkg::STORE_DEPTH - 1))
		else $error("clear length");
endmodule
